/* src/smoothstep_pose_interpolator_defines.svh */
// assertion helpers used by the checker file
`ifndef SMOOTHSTEP_POSE_INTERPOLATOR_DEFINES_SVH
`define SMOOTHSTEP_POSE_INTERPOLATOR_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define SSP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define SSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/ssp_pkg.sv */
package ssp_pkg;

  localparam int POS_BITS      = 21;
  localparam int HAND_CHANNELS = 8;
  localparam int CH_PORT_W     = 4;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_BEGIN = 2'd1,
    CMD_TICK  = 2'd2
  } command_e;

  // controller to datapath
  typedef struct packed {
    logic load_pose;
    logic begin_seg;
    logic tick_start;
    logic div_step;
    logic sq_step;
    logic cube_step;
    logic rd_issue;
    logic mul_step;
    logic emit;
    logic emit_idle;
    logic next_ch;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic active;
    logic div_last;
    logic ch_last;
    logic out_free;
  } dp_sts_t;

endpackage

/* src/ssp_ctrl.sv */
module ssp_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                command_i,
  input  ssp_pkg::dp_sts_t          sts_i,
  output ssp_pkg::dp_cmd_t          cmd_o
);
  import ssp_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_NOSEG  = 3'd1;
  localparam logic [2:0] S_DIV    = 3'd2;
  localparam logic [2:0] S_SQ     = 3'd3;
  localparam logic [2:0] S_CUBE   = 3'd4;
  localparam logic [2:0] S_RD     = 3'd5;
  localparam logic [2:0] S_MUL    = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (command_i == CMD_LOAD) begin
            cmd_o.load_pose = 1'b1;
          end else if (command_i == CMD_BEGIN) begin
            cmd_o.begin_seg = 1'b1;
          end else if (command_i == CMD_TICK) begin
            if (sts_i.active) begin
              cmd_o.tick_start = 1'b1;
              state_d          = S_DIV;
            end else begin
              state_d = S_NOSEG;
            end
          end
        end
      end
      S_NOSEG: begin
        if (sts_i.out_free) begin
          cmd_o.emit_idle = 1'b1;
          state_d         = S_IDLE;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_SQ;
        end
      end
      S_SQ: begin
        cmd_o.sq_step = 1'b1;
        state_d       = S_CUBE;
      end
      S_CUBE: begin
        cmd_o.cube_step = 1'b1;
        state_d         = S_RD;
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        state_d        = S_EMIT;
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.ch_last) begin
            state_d = S_IDLE;
          end else begin
            cmd_o.next_ch = 1'b1;
            state_d       = S_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/ssp_datapath.sv */
module ssp_datapath #(
  parameter int CHANNELS   = 16,
  parameter int FRAME_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssp_pkg::dp_cmd_t                    cmd_i,
  output ssp_pkg::dp_sts_t                    sts_o,
  input  logic [ssp_pkg::CH_PORT_W-1:0]       channel_i,
  input  logic signed [ssp_pkg::POS_BITS-1:0] start_value_i,
  input  logic signed [ssp_pkg::POS_BITS-1:0] end_value_i,
  input  logic [FRAME_BITS-1:0]               frame_total_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ssp_pkg::CH_PORT_W-1:0]       sample_channel_o,
  output logic signed [ssp_pkg::POS_BITS-1:0] position_o,
  output logic                                last_o,
  output logic                                segment_done_o,
  output logic                                idle_o
);
  import ssp_pkg::*;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int CNT_W  = $clog2(FRAC_BITS);
  localparam int DIFF_W = POS_BITS + 1;
  localparam int S_W    = FRAC_BITS + 1;
  localparam int PROD_W = DIFF_W + S_W + 1;
  localparam int SUM_W  = POS_BITS + 2;
  localparam int CUBE_W = 3 * FRAC_BITS + 2;
  localparam logic [FRAC_BITS+1:0] THREE_Q   = (FRAC_BITS + 2)'(3) << FRAC_BITS;
  localparam logic [CUBE_W-FRAC_BITS-1:0] ONE_WIDE = (CUBE_W - FRAC_BITS)'(1) << FRAC_BITS;
  localparam logic [S_W-1:0] ONE_Q = S_W'(1) << FRAC_BITS;

  // segment state
  logic [FRAME_BITS-1:0] frame_index_q, frame_limit_q, next_index;
  logic                  active_q, done_q, seg_done;

  // divider
  logic [FRAME_BITS:0]   rem_q, rem_sh;
  logic [FRAC_BITS-1:0]  quo_q;
  logic [CNT_W-1:0]      div_cnt_q;
  logic                  rem_ge;

  // smoothstep weight
  logic [2*FRAC_BITS-1:0]  sq_full;
  logic [FRAC_BITS-1:0]    f2_q;
  logic [FRAC_BITS+1:0]    g_val;
  logic [CUBE_W-1:0]       cube_full;
  logic [CUBE_W-FRAC_BITS-1:0] cube_s;
  logic [S_W-1:0]          s_q;

  // pose store
  logic [2*POS_BITS-1:0]   pose_mem [CHANNELS];
  logic [CHANNELS-1:0]     pose_vld_q;
  logic [2*POS_BITS-1:0]   rd_q;
  logic                    rd_vld_q;
  logic [CH_W-1:0]         ch_q, wr_addr;
  logic                    wr_in_range;
  logic signed [POS_BITS-1:0] rd_start, rd_end, start_q;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_q, prod_sh;
  logic signed [SUM_W-1:0]    sum, mag, mag_t, pos_val;
  logic                       hand;

  // result register
  logic                       out_valid_q, out_last_q, out_done_q, out_idle_q;
  logic [CH_PORT_W-1:0]       out_ch_q;
  logic signed [POS_BITS-1:0] out_pos_q;
  logic                       out_free;

  assign next_index = frame_index_q + FRAME_BITS'(1);
  assign seg_done   = (next_index >= frame_limit_q) || (next_index == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_index_q <= '0;
      frame_limit_q <= '0;
      active_q      <= 1'b0;
      done_q        <= 1'b0;
    end else if (cmd_i.begin_seg) begin
      frame_limit_q <= frame_total_i;
      frame_index_q <= '0;
      active_q      <= (frame_total_i != '0);
    end else if (cmd_i.tick_start) begin
      done_q <= seg_done;
      if (seg_done) begin
        frame_index_q <= '0;
        active_q      <= 1'b0;
      end else begin
        frame_index_q <= next_index;
      end
    end
  end

  // restoring division of (t << FRAC_BITS) by N, t < N, one quotient bit a cycle
  assign rem_sh = {rem_q[FRAME_BITS-1:0], 1'b0};
  assign rem_ge = (rem_sh >= {1'b0, frame_limit_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_cnt_q <= '0;
    end else if (cmd_i.tick_start) begin
      div_cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      div_cnt_q <= div_cnt_q + CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_start) begin
      rem_q <= {1'b0, frame_index_q};
      quo_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= rem_ge ? (rem_sh - {1'b0, frame_limit_q}) : rem_sh;
      quo_q <= {quo_q[FRAC_BITS-2:0], rem_ge};
    end
  end

  // s = f*f*(3 - 2f), from a squaring step into f2_q and then a cube step into s_q
  assign sq_full   = quo_q * quo_q;
  assign g_val     = THREE_Q - {1'b0, quo_q, 1'b0};
  assign cube_full = f2_q * g_val;
  assign cube_s    = cube_full[CUBE_W-1:FRAC_BITS];

  always_ff @(posedge clk_i) begin
    if (cmd_i.sq_step) begin
      f2_q <= sq_full[2*FRAC_BITS-1:FRAC_BITS];
    end
    if (cmd_i.cube_step) begin
      s_q <= (cube_s > ONE_WIDE) ? ONE_Q : cube_s[S_W-1:0];
    end
  end

  // endpoint store, entries read as zero until first written
  assign wr_addr     = CH_W'(channel_i);
  assign wr_in_range = (32'(channel_i) < 32'(CHANNELS));

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_pose && wr_in_range) begin
      pose_mem[wr_addr] <= {end_value_i, start_value_i};
    end
    if (cmd_i.rd_issue) begin
      rd_q <= pose_mem[ch_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pose_vld_q <= '0;
      rd_vld_q   <= 1'b0;
      ch_q       <= '0;
    end else begin
      if (cmd_i.load_pose && wr_in_range) begin
        pose_vld_q[wr_addr] <= 1'b1;
      end
      if (cmd_i.rd_issue) begin
        rd_vld_q <= pose_vld_q[ch_q];
      end
      if (cmd_i.tick_start) begin
        ch_q <= '0;
      end else if (cmd_i.next_ch) begin
        ch_q <= ch_q + CH_W'(1);
      end
    end
  end

  assign rd_start = rd_vld_q ? $signed(rd_q[POS_BITS-1:0]) : '0;
  assign rd_end   = rd_vld_q ? $signed(rd_q[2*POS_BITS-1:POS_BITS]) : '0;
  assign diff     = DIFF_W'(rd_end) - DIFF_W'(rd_start);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_step) begin
      prod_q  <= diff * $signed({1'b0, s_q});
      start_q <= rd_start;
    end
  end

  // floor shift, then hands truncated toward zero to whole units
  assign prod_sh = prod_q >>> FRAC_BITS;
  assign sum     = SUM_W'(start_q) + SUM_W'(prod_sh);
  assign hand    = (32'(ch_q) < 32'(HAND_CHANNELS));
  assign mag     = sum[SUM_W-1] ? -sum : sum;
  assign mag_t   = {mag[SUM_W-1:4], 4'b0000};
  assign pos_val = !hand ? sum : (sum[SUM_W-1] ? -mag_t : mag_t);

  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit || cmd_i.emit_idle) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_ch_q   <= CH_PORT_W'(ch_q);
      out_pos_q  <= pos_val[POS_BITS-1:0];
      out_last_q <= sts_o.ch_last;
      out_done_q <= done_q;
      out_idle_q <= 1'b0;
    end else if (cmd_i.emit_idle) begin
      out_ch_q   <= '0;
      out_pos_q  <= '0;
      out_last_q <= 1'b1;
      out_done_q <= 1'b0;
      out_idle_q <= 1'b1;
    end
  end

  assign sts_o.active   = active_q;
  assign sts_o.div_last = (div_cnt_q == CNT_W'(FRAC_BITS - 1));
  assign sts_o.ch_last  = (ch_q == CH_W'(CHANNELS - 1));
  assign sts_o.out_free = out_free;

  assign out_valid_o      = out_valid_q;
  assign sample_channel_o = out_ch_q;
  assign position_o       = out_pos_q;
  assign last_o           = out_last_q;
  assign segment_done_o   = out_done_q;
  assign idle_o           = out_idle_q;

endmodule

/* src/smoothstep_pose_interpolator.sv */
// smoothstep trajectory generator for CHANNELS joint channels
// input channel (in_valid_i / in_stall_o) carries one command per transaction:
//   load stores start and end position of one channel, begin starts a segment of
//   frame_total_i frames (0 leaves the block idle), tick produces one frame
// load and begin give no result
// a tick gives CHANNELS results on the output channel (out_valid_o / out_stall_i),
//   channel 0 first, last_o set on the final one; a tick with no segment running
//   gives a single result with idle_o set and position 0
// tick sequence: restoring division for t/N, then a square step and a cube step for the
//   smoothstep polynomial, then per channel a store read, a multiply, and an add and
//   truncate into the result register
// a new command is accepted in the cycle after the previous tick issued its last result
// a stalled result holds in the output register; the per-channel sequence waits
//   for it and resumes when the receiver takes it
// reset clears the segment state and marks all stored endpoints as zero
module smoothstep_pose_interpolator #(
  parameter int CHANNELS   = 16,
  parameter int FRAME_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          command_i,
  input  logic [ssp_pkg::CH_PORT_W-1:0]       channel_i,
  input  logic signed [ssp_pkg::POS_BITS-1:0] start_value_i,
  input  logic signed [ssp_pkg::POS_BITS-1:0] end_value_i,
  input  logic [FRAME_BITS-1:0]               frame_total_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [ssp_pkg::CH_PORT_W-1:0]       sample_channel_o,
  output logic signed [ssp_pkg::POS_BITS-1:0] position_o,
  output logic                                last_o,
  output logic                                segment_done_o,
  output logic                                idle_o
);
  import ssp_pkg::*;

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  ssp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .command_i  (command_i),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  ssp_datapath #(
    .CHANNELS   (CHANNELS),
    .FRAME_BITS (FRAME_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (dp_cmd),
    .sts_o            (dp_sts),
    .channel_i        (channel_i),
    .start_value_i    (start_value_i),
    .end_value_i      (end_value_i),
    .frame_total_i    (frame_total_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .sample_channel_o (sample_channel_o),
    .position_o       (position_o),
    .last_o           (last_o),
    .segment_done_o   (segment_done_o),
    .idle_o           (idle_o)
  );

endmodule

/* src/ssp_checker.sv */
`include "smoothstep_pose_interpolator_defines.svh"

module ssp_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic [ssp_pkg::CH_PORT_W-1:0]       sample_channel_o,
  input logic signed [ssp_pkg::POS_BITS-1:0] position_o,
  input logic                                last_o,
  input logic                                segment_done_o,
  input logic                                idle_o
);
  import ssp_pkg::*;

  // an idle transaction is a lone zero result
  `SSP_ASSERT_IMPL(a_idle_result, out_valid_o && idle_o, (position_o == '0) && last_o && !segment_done_o, "idle result malformed")

  // while a tick is still emitting no new command is taken
  `SSP_ASSERT_IMPL(a_busy_stall, out_valid_o && !last_o, in_stall_o, "input open during tick")

  // hand channels come out as whole numbers
  `SSP_ASSERT_IMPL(a_hand_whole, out_valid_o && !idle_o && (sample_channel_o < CH_PORT_W'(HAND_CHANNELS)), position_o[3:0] == 4'b0000, "hand sample not whole")

  // a stalled result holds
  `SSP_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(position_o) && $stable(sample_channel_o), "stalled result changed")

endmodule

bind smoothstep_pose_interpolator ssp_checker u_ssp_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .sample_channel_o (sample_channel_o),
  .position_o       (position_o),
  .last_o           (last_o),
  .segment_done_o   (segment_done_o),
  .idle_o           (idle_o)
);
